### rtl/bxg_pkg.sv
package bxg_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take a new item from the input ports
    logic strip;     // halve both operands, count the common power of two
    logic init;      // latch stripped operands, seed the coefficient pairs
    logic halve_s;   // halve a with its coefficient pair
    logic halve_t;   // halve b with its coefficient pair
    logic step;      // order the operands and subtract
    logic store;     // copy the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic a_odd;
    logic b_odd;
    logic b_zero;
  } sts_t;

endpackage

### rtl/bxg_ctrl.sv
module bxg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bxg_pkg::sts_t sts,
  output bxg_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STRIP  = 3'd1;
  localparam logic [2:0] ST_HALVE  = 3'd2;
  localparam logic [2:0] ST_LOOP   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the phases of one item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (sts.b_zero) begin
          state_nxt = ST_FINISH;
        end else if (!sts.a_odd && !sts.b_odd) begin
          cmd.strip = 1'b1;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = ST_HALVE;
        end
      end
      ST_HALVE: begin
        if (!sts.a_odd) begin
          cmd.halve_s = 1'b1;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.b_zero) begin
          state_nxt = ST_FINISH;
        end else if (!sts.b_odd) begin
          cmd.halve_t = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.store = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result valid until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.store) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/bxg_dpath.sv
module bxg_dpath #(
  parameter int N = 31
) (
  input  logic                 clk,
  input  bxg_pkg::cmd_t        cmd,
  output bxg_pkg::sts_t        sts,
  input  logic [N-1:0]         in_operand_a,
  input  logic [N-1:0]         in_operand_b,
  output logic [N-1:0]         out_gcd_value,
  output logic signed [N+2:0]  out_coef_a,
  output logic signed [N+2:0]  out_coef_b
);

  localparam int W  = N + 5;
  localparam int CW = N + 3;
  localparam int SW = $clog2(N);

  logic [N-1:0]         a_r, b_r;
  logic [SW-1:0]        sh_r;
  logic signed [W-1:0]  ra_r, rb_r, sa_r, sb_r, ta_r, tb_r;
  logic [N-1:0]         gcd_r;
  logic signed [CW-1:0] ca_r, cb_r;

  logic                 s_odd, t_odd, a_gt;
  logic signed [W-1:0]  sa_adj, sb_adj, ta_adj, tb_adj;
  logic signed [W-1:0]  a_ext, b_ext;

  assign sts.a_odd  = a_r[0];
  assign sts.b_odd  = b_r[0];
  assign sts.b_zero = (b_r == '0);

  assign a_ext = signed'({{(W-N){1'b0}}, a_r});
  assign b_ext = signed'({{(W-N){1'b0}}, b_r});

  // Make a coefficient pair even before it is halved
  assign s_odd  = sa_r[0] | sb_r[0];
  assign t_odd  = ta_r[0] | tb_r[0];
  assign sa_adj = s_odd ? (sa_r - rb_r) : sa_r;
  assign sb_adj = s_odd ? (sb_r + ra_r) : sb_r;
  assign ta_adj = t_odd ? (ta_r - rb_r) : ta_r;
  assign tb_adj = t_odd ? (tb_r + ra_r) : tb_r;

  assign a_gt = (a_r > b_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh_r <= '0;
      if (in_operand_a == '0) begin
        a_r  <= in_operand_b;
        b_r  <= '0;
        sa_r <= '0;
        sb_r <= W'(1);
      end else begin
        a_r  <= in_operand_a;
        b_r  <= in_operand_b;
        sa_r <= W'(1);
        sb_r <= '0;
      end
    end
    if (cmd.strip) begin
      a_r  <= a_r >> 1;
      b_r  <= b_r >> 1;
      sh_r <= sh_r + SW'(1);
    end
    if (cmd.init) begin
      ra_r <= a_ext;
      rb_r <= b_ext;
      sa_r <= W'(1);
      sb_r <= '0;
      ta_r <= '0;
      tb_r <= W'(1);
    end
    if (cmd.halve_s) begin
      a_r  <= a_r >> 1;
      sa_r <= sa_adj >>> 1;
      sb_r <= sb_adj >>> 1;
    end
    if (cmd.halve_t) begin
      b_r  <= b_r >> 1;
      ta_r <= ta_adj >>> 1;
      tb_r <= tb_adj >>> 1;
    end
    // Keep the smaller operand in a, the difference in b
    if (cmd.step) begin
      if (a_gt) begin
        a_r  <= b_r;
        b_r  <= a_r - b_r;
        sa_r <= ta_r;
        sb_r <= tb_r;
        ta_r <= sa_r - ta_r;
        tb_r <= sb_r - tb_r;
      end else begin
        b_r  <= b_r - a_r;
        ta_r <= ta_r - sa_r;
        tb_r <= tb_r - sb_r;
      end
    end
    // Restore the common power of two on the way out
    if (cmd.store) begin
      gcd_r <= a_r << sh_r;
      ca_r  <= sa_r[CW-1:0];
      cb_r  <= sb_r[CW-1:0];
    end
  end

  assign out_gcd_value = gcd_r;
  assign out_coef_a    = ca_r;
  assign out_coef_b    = cb_r;

endmodule

### rtl/binary_extended_gcd.sv
// Binary extended GCD: gcd_value = coef_a * operand_a + coef_b * operand_b.
// Input channel: in_valid / in_ready with in_operand_a and in_operand_b,
// both unsigned OPERAND_BITS wide. Result channel: out_valid / out_ready
// with out_gcd_value (unsigned) and out_coef_a, out_coef_b (two's
// complement, OPERAND_BITS+3 wide). Every item gives exactly one result.
// One item is worked at a time; in_ready is high while the engine is idle.
// After accept, the engine strips the common power of two, halves both
// working operands and runs the subtract steps, all one per cycle through
// the shared shift and subtract datapath; a zero operand goes straight to
// the result, with no strip, halve or subtract step.
// The result sits in an output register; the engine can take the next item
// while it waits, and if the receiver stalls while a second result is
// finished, that result holds in the engine until the register frees.
// Reset (rst_n, synchronous, active low) drops any item in flight and any
// undelivered result; the datapath registers themselves are not reset.
module binary_extended_gcd #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OPERAND_BITS-1:0]       in_operand_a,
  input  logic [OPERAND_BITS-1:0]       in_operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OPERAND_BITS-1:0]       out_gcd_value,
  output logic signed [OPERAND_BITS+2:0] out_coef_a,
  output logic signed [OPERAND_BITS+2:0] out_coef_b
);

  bxg_pkg::cmd_t cmd;
  bxg_pkg::sts_t sts;

  bxg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bxg_dpath #(
    .N (OPERAND_BITS)
  ) u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_gcd_value (out_gcd_value),
    .out_coef_a    (out_coef_a),
    .out_coef_b    (out_coef_b)
  );

endmodule

### tb/binary_extended_gcd_test.sv
module binary_extended_gcd_test;

  localparam int OPB        = 31;
  localparam int COEFB      = OPB + 3;
  localparam int DIRECTED_N = 24;
  localparam int RANDOM_N   = 530;
  localparam int DRAIN      = 3 * OPB + 10;
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_AT    = 150;
  localparam int HOLD_LEN   = 500;
  localparam int QUIET_LO   = 15000;
  localparam int QUIET_HI   = 26000;

  localparam logic [OPB-1:0] OPND_MAX = '1;

  typedef struct packed {
    logic [OPB-1:0] a;
    logic [OPB-1:0] b;
  } opnd_pair_t;

  typedef struct packed {
    logic [OPB-1:0]   gcd;
    logic [COEFB-1:0] ca;
    logic [COEFB-1:0] cb;
  } bezout_t;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic [OPB-1:0]          in_operand_a  = '0;
  logic [OPB-1:0]          in_operand_b  = '0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic [OPB-1:0]          out_gcd_value;
  logic signed [COEFB-1:0] out_coef_a;
  logic signed [COEFB-1:0] out_coef_b;

  opnd_pair_t pending_pairs[$];
  bezout_t    bezout_due[$];
  int         cycle_count  = 0;
  int         results_seen = 0;
  int         mismatches   = 0;
  int         hold_left    = 0;
  bit         hold_done    = 1'b0;

  binary_extended_gcd #(
    .OPERAND_BITS(OPB)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_gcd_value(out_gcd_value),
    .out_coef_a   (out_coef_a),
    .out_coef_b   (out_coef_b)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Make the pair even if needed, then halve both coefficients exactly
  function automatic void halve_coefs(inout logic [63:0] p, inout logic [63:0] q,
                                      input logic [63:0] ra, input logic [63:0] rb);
    if ((p[0] | q[0]) != 1'b0) begin
      p = p - rb;
      q = q + ra;
    end
    p = {p[63], p[63:1]};
    q = {q[63], q[63:1]};
  endfunction

  // Binary extended gcd with its Bezout pair, worked at 64 bits
  function automatic bezout_t bezout_of(logic [OPB-1:0] opa, logic [OPB-1:0] opb);
    logic [63:0] a, b, ra, rb, sa, sb, ta, tb, tmp, d, s, t;
    int          shift;
    bezout_t     res;
    a = 64'(opa);
    b = 64'(opb);
    shift = 0;
    if (a == 0) begin
      d = b; s = 0; t = 1;
    end else if (b == 0) begin
      d = a; s = 1; t = 0;
    end else begin
      // strip the common power of two
      while (((a | b) & 64'd1) == 0) begin
        a = a >> 1;
        b = b >> 1;
        shift++;
      end
      ra = a;
      rb = b;
      sa = 1; sb = 0;
      ta = 0; tb = 1;
      while (a[0] == 1'b0) begin
        halve_coefs(sa, sb, ra, rb);
        a = a >> 1;
      end
      while (b != 0) begin
        while (b[0] == 1'b0) begin
          halve_coefs(ta, tb, ra, rb);
          b = b >> 1;
        end
        // keep a as the smaller operand, swapping the pairs with it
        if (a > b) begin
          tmp = a;  a = b;   b = tmp;
          tmp = sa; sa = ta; ta = tmp;
          tmp = sb; sb = tb; tb = tmp;
        end
        b  = b - a;
        ta = ta - sa;
        tb = tb - sb;
      end
      d = a << shift;
      s = sa;
      t = sb;
    end
    res.gcd = d[OPB-1:0];
    res.ca  = s[COEFB-1:0];
    res.cb  = t[COEFB-1:0];
    return res;
  endfunction

  function automatic opnd_pair_t make_pair(logic [31:0] x, logic [31:0] y);
    opnd_pair_t p;
    p.a = x[OPB-1:0];
    p.b = y[OPB-1:0];
    return p;
  endfunction

  // Random operand pair drawn from a few shapes
  function automatic opnd_pair_t random_pair();
    logic [31:0] x, y, g;
    int          sh;
    int          pick;
    pick = $urandom_range(0, 9);
    x = $urandom();
    y = $urandom();
    case (pick)
      4, 5: begin
        // shared power of two, strip loop runs long
        sh = $urandom_range(1, OPB - 1);
        x = x << sh;
        y = y << ($urandom_range(0, 1) ? sh : $urandom_range(sh, OPB - 1));
        if (x[OPB-1:0] == 0) x[sh] = 1'b1;
        if (y[OPB-1:0] == 0) y[sh] = 1'b1;
      end
      6: begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end
      7: begin
        // large common factor
        g = $urandom_range(1, 65535);
        x = g * $urandom_range(1, 32767);
        y = g * $urandom_range(1, 32767);
      end
      8: begin
        if ($urandom_range(0, 1)) x = 0;
        else y = 0;
      end
      9: begin
        x = 32'(OPND_MAX) - $urandom_range(0, 15);
        y = $urandom_range(0, 1) ? 32'(OPND_MAX) - $urandom_range(0, 15) : y;
      end
      default: begin
      end
    endcase
    return make_pair(x, y);
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 14;
  endfunction

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("binary_extended_gcd test failed");
      $finish;
    end
  end

  // Sender: hold each item until accepted, then maybe idle before the next
  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        bezout_due.push_back(bezout_of(in_operand_a, in_operand_b));
        void'(pending_pairs.pop_front());
        offer = 1'b0;
      end
      if (!offer && pending_pairs.size() > 0 && !idle_now()) begin
        in_operand_a <= pending_pairs[0].a;
        in_operand_b <= pending_pairs[0].b;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now();
    end
  end

  // Check each delivered result against the oldest prediction
  always @(posedge clk) begin
    bezout_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (bezout_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: gcd=%0d coef_a=%0d coef_b=%0d",
                   out_gcd_value, out_coef_a, out_coef_b);
      end else begin
        want = bezout_due.pop_front();
        if (out_gcd_value !== want.gcd || out_coef_a !== want.ca ||
            out_coef_b !== want.cb) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: gcd %0d/%0d coef_a %0d/%0d coef_b %0d/%0d (exp/act)",
                     want.gcd, out_gcd_value, $signed(want.ca), out_coef_a,
                     $signed(want.cb), out_coef_b);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    opnd_pair_t dir_pairs[DIRECTED_N];
    dir_pairs = '{
      make_pair(0, 0),
      make_pair(0, 32'(OPND_MAX)),
      make_pair(32'(OPND_MAX), 0),
      make_pair(0, 5),
      make_pair(7, 0),
      make_pair(1, 1),
      make_pair(32'(OPND_MAX), 32'(OPND_MAX)),
      make_pair(1, 32'(OPND_MAX)),
      make_pair(32'(OPND_MAX), 1),
      make_pair(32'(OPND_MAX), 32'(OPND_MAX) - 1),
      make_pair(32'h4000_0000, 32'h4000_0000),
      make_pair(32'h4000_0000, 32'h2000_0000),
      make_pair(32'h4000_0000, 3),
      make_pair(3, 32'h4000_0000),
      make_pair(6, 4),
      make_pair(12, 18),
      make_pair(8, 3),
      make_pair(9, 16),
      make_pair(32'h5555_5555, 32'h2AAA_AAAA),
      make_pair(32'h2AAA_AAAA, 32'h5555_5555),
      make_pair(2, 2),
      make_pair(1134903170, 1836311903),
      make_pair(1836311903, 1134903170),
      make_pair(32'h6000_0000, 32'h1800_0000)
    };
    foreach (dir_pairs[i]) pending_pairs.push_back(dir_pairs[i]);
    repeat (RANDOM_N) pending_pairs.push_back(random_pair());

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || bezout_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && bezout_due.size() == 0) begin
      $display("binary_extended_gcd test passed");
    end else begin
      $display("binary_extended_gcd test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/bxg_pkg.sv
rtl/bxg_ctrl.sv
rtl/bxg_dpath.sv
rtl/binary_extended_gcd.sv
tb/binary_extended_gcd_test.sv
